// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the convolution RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CNV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CNV_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CNV_ASSERT(lbl, clk, rst, prop, msg)
`define CNV_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/core/cnv_pkg.sv =====
// Shared constants, register codes and types for the 3x3 convolution.
// No dependencies; imported by every module of the block.
package cnv_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int XW        = $clog2(MAX_WIDTH);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int YW        = 17;
   localparam int PIX_W     = 8;
   localparam int NCH       = 3;
   localparam int PX_W      = PIX_W * NCH;
   localparam int TAPS      = 9;
   localparam int COEF_W    = 12;
   localparam int PROD_W    = 21;
   localparam int ROW_W     = 23;
   localparam int RES_W     = 25;
   localparam int FRAC_MAX  = 11;
   localparam int STAGES    = 6;

   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CFG_KROW_W   = 3 * COEF_W;
   localparam int CSR_AW       = 6;
   localparam int CSR_DW       = 64;
   localparam int OUT_DW       = ((NCH * RES_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      REG_WIDTH,
      REG_HEIGHT,
      REG_CHANS,
      REG_KEEP,
      REG_KTOP,
      REG_KMID,
      REG_KBOT,
      REG_FRAC
   } cnv_reg_type;

   typedef logic [PX_W-1:0]          cnv_px_type;
   typedef logic signed [COEF_W-1:0] cnv_coef_type;
   typedef logic signed [RES_W-1:0]  cnv_res_type;
   typedef logic [STAGES:1]          cnv_en_type;

   // one accepted pixel or drain item headed for the window stage
   typedef struct packed {
      logic [XW-1:0] addr;
      cnv_px_type    px;
      logic          col_first;
      logic          col_second;
      logic          row_second;
      logic          drain;
   } cnv_item_type;

   typedef struct packed {
      logic [1:0] chans;
      logic       keep;
      logic [3:0] frac;
   } cnv_mode_type;

endpackage

// ===== rtl/core/cnv_window.sv =====
// Line memory, column shift registers and 3x3 window register with
// edge replication. Depends on cnv_pkg.
module cnv_window (
   input  logic                                    clock,
   input  cnv_pkg::cnv_en_type                     en,
   input  logic                                    s1_move,
   input  cnv_pkg::cnv_item_type                   item,
   output cnv_pkg::cnv_px_type [cnv_pkg::TAPS-1:0] win
);
   import cnv_pkg::*;

   // column of three pixels, index 0 is the top row
   typedef cnv_px_type [2:0] col_type;

   logic [2*PX_W-1:0]       mem [MAX_WIDTH];
   logic [2*PX_W-1:0]       rd_ff;
   cnv_item_type            item_ff;
   col_type                 col0_ff, col1_ff, col_new, left, right;
   cnv_px_type [TAPS-1:0]   win_ff, win_in;
   cnv_px_type              older, newer;

   // memory word at column x: {row two above, row above}
   always_ff @(posedge clock) begin
      if (en[1]) begin
         item_ff <= item;
         rd_ff   <= mem[item.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && !item_ff.drain) begin
         mem[item_ff.addr] <= {newer, item_ff.px};
      end
   end

   always_comb begin
      older = rd_ff[2*PX_W-1:PX_W];
      newer = rd_ff[PX_W-1:0];
      col_new[0] = item_ff.row_second ? newer : older;
      col_new[1] = newer;
      col_new[2] = item_ff.drain ? newer : item_ff.px;
      if (item_ff.col_first) begin
         // center sits on the right edge of the previous row
         left  = col1_ff;
         right = col0_ff;
      end else begin
         left  = item_ff.col_second ? col0_ff : col1_ff;
         right = col_new;
      end
      for (int r = 0; r < 3; r++) begin
         win_in[3*r]     = left[r];
         win_in[3*r + 1] = col0_ff[r];
         win_in[3*r + 2] = right[r];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         col1_ff <= col0_ff;
         col0_ff <= col_new;
      end
      if (en[2]) begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

endmodule

// ===== rtl/core/cnv_lane.sv =====
// One channel lane: nine tap products, row sums and lane total.
// Depends on cnv_pkg.
module cnv_lane (
   input  logic                                           clock,
   input  cnv_pkg::cnv_en_type                            en,
   input  logic [cnv_pkg::TAPS-1:0][cnv_pkg::PIX_W-1:0]   taps,
   input  cnv_pkg::cnv_coef_type [cnv_pkg::TAPS-1:0]      coef,
   output cnv_pkg::cnv_res_type                           sum
);
   import cnv_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic signed [ROW_W-1:0]  row_ff [3];
   cnv_res_type              sum_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < TAPS; i++) begin
            prod_ff[i] <= PROD_W'($signed({1'b0, taps[i]})) * PROD_W'($signed(coef[i]));
         end
      end
      if (en[4]) begin
         for (int r = 0; r < 3; r++) begin
            row_ff[r] <= ROW_W'(prod_ff[3*r]) + ROW_W'(prod_ff[3*r + 1])
                       + ROW_W'(prod_ff[3*r + 2]);
         end
      end
      if (en[5]) begin
         sum_ff <= RES_W'(row_ff[0]) + RES_W'(row_ff[1]) + RES_W'(row_ff[2]);
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/core/cnv_merge.sv =====
// Merges lane totals: inactive lanes zeroed, optional channel sum,
// arithmetic shift, result register. Depends on cnv_pkg.
module cnv_merge (
   input  logic                                      clock,
   input  cnv_pkg::cnv_en_type                       en,
   input  cnv_pkg::cnv_mode_type                     mode,
   input  cnv_pkg::cnv_res_type [cnv_pkg::NCH-1:0]   lane_sum,
   output cnv_pkg::cnv_res_type [cnv_pkg::NCH-1:0]   result
);
   import cnv_pkg::*;

   cnv_res_type [NCH-1:0] masked, res_in, res_ff;
   cnv_res_type           total;

   always_comb begin
      total = '0;
      for (int l = 0; l < NCH; l++) begin
         masked[l] = (2'(l) < mode.chans) ? lane_sum[l] : '0;
         total     = $signed(total) + $signed(masked[l]);
      end
      res_in = '0;
      if (mode.keep) begin
         for (int l = 0; l < NCH; l++) begin
            res_in[l] = $signed(masked[l]) >>> mode.frac;
         end
      end else begin
         res_in[0] = $signed(total) >>> mode.frac;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== rtl/core/conv3x3_replicate_border.sv =====
// Top level of the streaming 3x3 convolution with replicated borders:
// registers, raster counters, stage valids, three lanes and the merge.
// Depends on cnv_pkg, cnv_window, cnv_lane, cnv_merge, assert_macros.svh.
//
//  channel  | dir | ports                      | payload
//  ---------+-----+----------------------------+---------------------------------
//  req      | in  | tvalid tready tdata tuser  | three 8-bit samples, func
//  rsp      | out | tvalid tready tdata tlast  | three 25-bit results, frame_last
//  csr      | in  | psel penable pwrite paddr  | eight registers at 8*i, 64-bit
//
// One item per clock sustained while rsp_tready holds; the pixel (or drain) that
// completes a window passes one register per stage on the way to the output:
// window fetch, window, products, row sums, lane sums, merge.
// The line memory gives one read and one write per cycle, which sets the rate.
// No clearing pass after reset; words not yet written feed only dropped results.
// A full output register stalls only stages with no bubble ahead of them.
`include "assert_macros.svh"

module conv3x3_replicate_border (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // sample_ch0 [7:0], sample_ch1 [15:8], sample_ch2 [23:16]
   input  logic [cnv_pkg::PX_W-1:0]      req_tdata,
   // func
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // result_ch0 [24:0], result_ch1 [49:25], result_ch2 [74:50], zero fill
   output logic [cnv_pkg::OUT_DW-1:0]    rsp_tdata,
   // frame_last
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cnv_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [cnv_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [cnv_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import cnv_pkg::*;

   // configuration registers
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [1:0]              chans_ff;
   logic                    keep_ff;
   logic [CFG_KROW_W-1:0]   ktop_ff, kmid_ff, kbot_ff;
   logic [3:0]              frac_ff;
   cnv_reg_type             reg_idx;
   logic                    csr_wr, geo_wr;

   // raster position of the next item
   logic [XW-1:0]           pix_x_ff, pix_x_in;
   logic [YW-1:0]           pix_y_ff, pix_y_in;

   logic [WW-1:0]           eff_w;
   logic [XW-1:0]           w_last;
   logic [CFG_HEIGHT_W-1:0] eff_h;
   logic [YW-1:0]           h17;
   cnv_mode_type            mode;

   logic                    acc, pix_ok, drn_ok, take, at_end, emit;
   cnv_item_type            item;

   cnv_en_type              can, v_ff, v_in, last_ff, last_in;
   logic                    em1_ff;
   logic                    s1_move;

   cnv_px_type [TAPS-1:0]                win;
   cnv_coef_type [TAPS-1:0]              coef;
   logic [NCH-1:0][TAPS-1:0][PIX_W-1:0]  taps;
   cnv_res_type [NCH-1:0]                lane_sum;
   cnv_res_type [NCH-1:0]                result;

   // ---------------- register port ----------------
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = cnv_reg_type'(csr_paddr[CSR_AW-1:3]);
   assign geo_wr     = csr_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_WIDTH_W'(1024);
         height_ff <= CFG_HEIGHT_W'(1024);
         chans_ff  <= 2'd1;
         keep_ff   <= 1'b1;
         ktop_ff   <= '0;
         kmid_ff   <= '0;
         kbot_ff   <= '0;
         frac_ff   <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
            REG_CHANS:  chans_ff  <= csr_pwdata[1:0];
            REG_KEEP:   keep_ff   <= csr_pwdata[0];
            REG_KTOP:   ktop_ff   <= csr_pwdata[CFG_KROW_W-1:0];
            REG_KMID:   kmid_ff   <= csr_pwdata[CFG_KROW_W-1:0];
            REG_KBOT:   kbot_ff   <= csr_pwdata[CFG_KROW_W-1:0];
            REG_FRAC:   frac_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         REG_CHANS:  csr_prdata = CSR_DW'(chans_ff);
         REG_KEEP:   csr_prdata = CSR_DW'(keep_ff);
         REG_KTOP:   csr_prdata = CSR_DW'(ktop_ff);
         REG_KMID:   csr_prdata = CSR_DW'(kmid_ff);
         REG_KBOT:   csr_prdata = CSR_DW'(kbot_ff);
         REG_FRAC:   csr_prdata = CSR_DW'(frac_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- effective settings ----------------
   always_comb begin
      if (width_ff < CFG_WIDTH_W'(2)) begin
         eff_w = WW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      w_last     = XW'(eff_w - WW'(1));
      eff_h      = (height_ff < CFG_HEIGHT_W'(2)) ? CFG_HEIGHT_W'(2) : height_ff;
      h17        = YW'(eff_h);
      mode.chans = (chans_ff == 2'd0) ? 2'd1 : chans_ff;
      mode.keep  = keep_ff;
      mode.frac  = (frac_ff > 4'(FRAC_MAX)) ? 4'(FRAC_MAX) : frac_ff;
      for (int c = 0; c < 3; c++) begin
         coef[c]     = ktop_ff[COEF_W*c +: COEF_W];
         coef[3 + c] = kmid_ff[COEF_W*c +: COEF_W];
         coef[6 + c] = kbot_ff[COEF_W*c +: COEF_W];
      end
   end

   // ---------------- accept and raster counters ----------------
   // rows past the last one are virtual rows walked by drain items
   always_comb begin
      acc    = req_tvalid && req_tready;
      pix_ok = !req_tuser && (pix_y_ff < h17);
      drn_ok = req_tuser && (pix_y_ff >= h17);
      take   = acc && (pix_ok || drn_ok);
      at_end = drn_ok && (pix_y_ff == h17 + YW'(1));
      emit   = req_tuser || (pix_y_ff >= YW'(2))
            || (pix_y_ff == YW'(1) && pix_x_ff != '0);

      pix_x_in = pix_x_ff;
      pix_y_in = pix_y_ff;
      if (geo_wr) begin
         pix_x_in = '0;
         pix_y_in = '0;
      end else if (take) begin
         if (at_end) begin
            pix_x_in = '0;
            pix_y_in = '0;
         end else if (pix_x_ff == w_last) begin
            pix_x_in = '0;
            pix_y_in = pix_y_ff + YW'(1);
         end else begin
            pix_x_in = pix_x_ff + XW'(1);
         end
      end

      item.addr       = pix_x_ff;
      item.col_first  = (pix_x_ff == '0);
      item.col_second = (pix_x_ff == XW'(1));
      item.row_second = (pix_y_ff == YW'(1));
      item.drain      = req_tuser;
      for (int l = 0; l < NCH; l++) begin
         item.px[PIX_W*l +: PIX_W] = (2'(l) < mode.chans) ? req_tdata[PIX_W*l +: PIX_W] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_x_ff <= '0;
         pix_y_ff <= '0;
      end else begin
         pix_x_ff <= pix_x_in;
         pix_y_ff <= pix_y_in;
      end
   end

   // ---------------- stage valids ----------------
   // a stage loads when it is empty or its content moves on
   always_comb begin
      can[STAGES] = !v_ff[STAGES] || rsp_tready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         can[k] = !v_ff[k] || can[k + 1];
      end
      v_in[1]    = take;
      last_in[1] = at_end;
      v_in[2]    = v_ff[1] && em1_ff;
      last_in[2] = last_ff[1];
      for (int k = 3; k <= STAGES; k++) begin
         v_in[k]    = v_ff[k - 1];
         last_in[k] = last_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         last_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (can[k]) begin
               v_ff[k]    <= v_in[k];
               last_ff[k] <= last_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (can[1]) begin
         em1_ff <= emit;
      end
   end

   assign s1_move    = v_ff[1] && can[2];
   assign req_tready = can[1];
   assign rsp_tvalid = v_ff[STAGES];
   assign rsp_tlast  = last_ff[STAGES];

   // ---------------- datapath ----------------
   cnv_window u_window (
      .clock   (clock),
      .en      (can),
      .s1_move (s1_move),
      .item    (item),
      .win     (win)
   );

   always_comb begin
      for (int l = 0; l < NCH; l++) begin
         for (int i = 0; i < TAPS; i++) begin
            taps[l][i] = win[i][PIX_W*l +: PIX_W];
         end
      end
   end

   for (genvar l = 0; l < NCH; l++) begin : g_lane
      cnv_lane u_lane (
         .clock (clock),
         .en    (can),
         .taps  (taps[l]),
         .coef  (coef),
         .sum   (lane_sum[l])
      );
   end

   cnv_merge u_merge (
      .clock    (clock),
      .en       (can),
      .mode     (mode),
      .lane_sum (lane_sum),
      .result   (result)
   );

   assign rsp_tdata = {{(OUT_DW - NCH*RES_W){1'b0}}, result};

   // ---------------- checks ----------------
   `CNV_ASSERT(a_col_in_row, clock, reset, pix_x_ff <= w_last, "column counter past row end")
   `CNV_ASSERT(a_row_bound, clock, reset, pix_y_ff <= h17 + YW'(1), "row counter past drain rows")
   `CNV_ASSERT(a_frame_wrap, clock, reset, take && at_end |=> pix_x_ff == '0 && pix_y_ff == '0, "counters not cleared at frame end")

endmodule
